// ----- src/lid_pkg.sv -----
// Shared constants, codes, command and status types, and helpers for the interpolating differentiator.
package lid_pkg;

  localparam int MAX_POINTS = 8;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int XP_W       = 34;
  localparam int S_W        = 40;
  localparam int DIV_W      = 64;
  localparam int COEF_W     = 6;

  localparam logic [1:0] REG_ORDER = 2'd0;
  localparam logic [1:0] REG_STEP  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  localparam logic [1:0]  ORDER_RESET = 2'd1;
  localparam logic [30:0] STEP_RESET  = 31'd19661;
  localparam logic [3:0]  COUNT_RESET = 4'd8;

  localparam logic [1:0] ORD_NONE   = 2'd0;
  localparam logic [1:0] ORD_FIRST  = 2'd1;
  localparam logic [1:0] ORD_SECOND = 2'd2;
  localparam logic [1:0] ORD_THIRD  = 2'd3;

  localparam logic [2:0] EV_PLUS_H   = 3'd0;
  localparam logic [2:0] EV_MINUS_H  = 3'd1;
  localparam logic [2:0] EV_PLUS_2H  = 3'd2;
  localparam logic [2:0] EV_MINUS_2H = 3'd3;
  localparam logic [2:0] EV_CENTER   = 3'd4;

  localparam logic signed [63:0] ONE_FX    = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] FRAC_MASK = ONE_FX - 64'sd1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_QSTART,
    OP_CAP_X0,
    OP_CAP_XL,
    OP_EV_START,
    OP_K_INIT,
    OP_K_CAP,
    OP_I_MUL,
    OP_DIV_START,
    OP_LW_UPD,
    OP_Y_MUL,
    OP_Y_ACC,
    OP_EV_CLAMP,
    OP_EV_SUM,
    OP_FIN_START,
    OP_POW_START,
    OP_V_UPD,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] addr;
    logic [2:0]       eval_idx;
  } lid_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] n_pts;
    logic [1:0]       order;
    logic             in_span;
    logic             den_zero;
    logic             div_done;
    logic             out_valid;
  } lid_stat_t;

  // Stencil weight of one evaluation point for a given derivative order.
  function automatic logic signed [COEF_W-1:0] coef(input logic [1:0] ord,
                                                    input logic [2:0] e);
    logic signed [COEF_W-1:0] c;
    c = '0;
    unique case (ord)
      ORD_FIRST: begin
        if (e == EV_PLUS_H) c = 6'sd8;
        else if (e == EV_MINUS_H) c = -6'sd8;
        else if (e == EV_PLUS_2H) c = -6'sd1;
        else if (e == EV_MINUS_2H) c = 6'sd1;
      end
      ORD_SECOND: begin
        if (e == EV_PLUS_H || e == EV_MINUS_H) c = 6'sd16;
        else if (e == EV_PLUS_2H || e == EV_MINUS_2H) c = -6'sd1;
        else if (e == EV_CENTER) c = -6'sd30;
      end
      ORD_THIRD: begin
        if (e == EV_PLUS_H) c = -6'sd2;
        else if (e == EV_MINUS_H) c = 6'sd2;
        else if (e == EV_PLUS_2H) c = 6'sd1;
        else if (e == EV_MINUS_2H) c = -6'sd1;
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return v != {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (!ovf32(v)) r = v[31:0];
    else if (v[63]) r = 32'sh8000_0000;
    else r = 32'sh7FFF_FFFF;
    return r;
  endfunction

endpackage

// ----- src/lagrange_interp_derivative.sv -----
// Operation: a load beat is taken in the idle state; a query works through each stencil point
// (E = 4 stencil points, 5 for the second derivative), each Lagrange term and its factors.
// Items are handled one at a time; query time is set by the shared bit-serial divider, which
// produces 64 quotient bits per Lagrange factor and per division.
// Reset: synchronous, active high; configuration returns to order 1, h = 19661, n = 8.
module lagrange_interp_derivative (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic signed [31:0] sample_x,
  input  logic signed [31:0] sample_y,
  input  logic signed [31:0] query_x,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] derivative,
  output logic               out_of_span,
  output logic               saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import lid_pkg::*;

  lid_cmd_t  cmd;
  lid_stat_t stat;

  // Configuration registers accept a write beat in any cycle. Writes are only
  // expected while the block is idle, so no interlock with a running query.
  assign cfg_ready = 1'b1;

  // The controller walks the stencil points, the Lagrange basis terms and the
  // factors inside each term, and finally the divisions by the step. Loads are
  // taken in the idle state. The result sits in the output register of the
  // datapath, so a new beat may be accepted while it waits to be taken.
  lid_ctrl u_ctrl (
    .clk, .rst,
    .in_valid, .kind, .in_ready,
    .out_ready,
    .stat, .cmd
  );

  // The datapath holds the point stores, all arithmetic and the one shared
  // divider used by every Lagrange factor with a nonzero denominator and every scaling by the step.
  lid_datapath u_dp (
    .clk, .rst,
    .cmd, .stat,
    .sample_x, .sample_y, .query_x,
    .cfg_valid, .cfg_index, .cfg_data,
    .out_ready, .out_valid, .derivative, .out_of_span, .saturated
  );

endmodule

// ----- src/lid_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- src/lid_div.sv -----
// Bit-serial signed divider, one quotient bit per cycle, truncating toward zero.
module lid_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [lid_pkg::DIV_W-1:0] num,
  input  logic signed [lid_pkg::DIV_W-1:0] den,
  output logic signed [lid_pkg::DIV_W-1:0] quo,
  output logic                            done
);
  import lid_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] dvd;
  logic [DIV_W-1:0] dsr;
  logic             neg;
  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DIV_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem[DIV_W-1:0], dvd[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr};
  assign quo    = neg ? -signed'(dvd) : signed'(dvd);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(DIV_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_W - 1)) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
      dsr <= den[DIV_W-1] ? DIV_W'(-den) : DIV_W'(den);
      neg <= num[DIV_W-1] ^ den[DIV_W-1];
    end else if (busy) begin
      rem <= ge ? rem_sh - {1'b0, dsr} : rem_sh;
      dvd <= {dvd[DIV_W-2:0], ge};
    end
  end

endmodule

// ----- src/lid_datapath.sv -----
// Datapath: configuration registers, point stores, Lagrange arithmetic, stencil and output register.
module lid_datapath (
  input  logic                    clk,
  input  logic                    rst,
  input  lid_pkg::lid_cmd_t       cmd,
  output lid_pkg::lid_stat_t      stat,
  input  logic signed [31:0]      sample_x,
  input  logic signed [31:0]      sample_y,
  input  logic signed [31:0]      query_x,
  input  logic                    cfg_valid,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [31:0]      derivative,
  output logic                    out_of_span,
  output logic                    saturated
);
  import lid_pkg::*;

  logic [1:0]              ord_r;
  logic [30:0]             step_r;
  logic [3:0]              pcnt_r;
  logic [CNT_W-1:0]        load_idx;
  logic [CNT_W-1:0]        n_pts;
  logic [CNT_W-1:0]        slot;
  logic [CNT_W-1:0]        slot_inc;
  logic [7:0]              pc_ext;
  logic [30:0]             h_eff;

  logic signed [31:0]      q_r, x0_r, xl_r, xk_r, yk_r, lw_r, p_r, v_r;
  logic signed [XP_W-1:0]  xp_r, xp_next, off;
  logic signed [XP_W-1:0]  h1, h2;
  logic signed [63:0]      prod_r, acc_r;
  logic signed [32:0]      den_r, den_w;
  logic signed [XP_W:0]    num_w;
  logic signed [XP_W+32:0] mul_li;
  logic signed [S_W-1:0]   s_r;
  logic signed [COEF_W+31:0] cp;
  logic                    oos_r, sat_r;
  logic signed [31:0]      x_rd, y_rd, lw_special;

  logic                    div_start, div_done;
  logic signed [DIV_W-1:0] div_num, div_den, div_q;
  logic [DIV_W-1:0]        fin_den;

  assign pc_ext = 8'(pcnt_r);
  always_comb begin
    if (pc_ext < 8'd2) n_pts = CNT_W'(2);
    else if (pc_ext > 8'(MAX_POINTS)) n_pts = CNT_W'(MAX_POINTS);
    else n_pts = CNT_W'(pcnt_r);
  end

  assign h_eff    = (step_r == '0) ? 31'd1 : step_r;
  assign slot     = (load_idx < n_pts) ? load_idx : '0;
  assign slot_inc = slot + 1'b1;

  lid_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_xram (
    .clk, .we(cmd.op == OP_LOAD), .waddr(slot[IDX_W-1:0]), .wdata(sample_x),
    .raddr(cmd.addr), .rdata(x_rd)
  );
  lid_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_yram (
    .clk, .we(cmd.op == OP_LOAD), .waddr(slot[IDX_W-1:0]), .wdata(sample_y),
    .raddr(cmd.addr), .rdata(y_rd)
  );

  // Stencil point offsets from the query point.
  assign h1 = signed'({3'b000, h_eff});
  assign h2 = h1 <<< 1;
  always_comb begin
    unique case (cmd.eval_idx)
      EV_PLUS_H:   off = h1;
      EV_MINUS_H:  off = -h1;
      EV_PLUS_2H:  off = h2;
      EV_MINUS_2H: off = -h2;
      default:     off = '0;
    endcase
  end
  assign xp_next = XP_W'(q_r) + off;

  assign num_w  = (XP_W+1)'(xp_r) - (XP_W+1)'(x_rd);
  assign den_w  = 33'(xk_r) - 33'(x_rd);
  assign mul_li = lw_r * num_w;
  assign cp     = coef(ord_r, cmd.eval_idx) * p_r;

  always_comb begin
    if (num_w == '0 || lw_r == '0) lw_special = '0;
    else if (lw_r[31] != num_w[XP_W]) lw_special = 32'sh8000_0000;
    else lw_special = 32'sh7FFF_FFFF;
  end

  assign fin_den = (ord_r == ORD_THIRD) ? (DIV_W'(h_eff) << 1)
                                        : (DIV_W'(h_eff) << 3) + (DIV_W'(h_eff) << 2);
  always_comb begin
    div_start = 1'b1;
    div_num   = prod_r;
    div_den   = DIV_W'(den_r);
    unique case (cmd.op)
      OP_DIV_START: ;
      OP_FIN_START: begin
        div_num = DIV_W'(s_r) <<< FRAC_BITS;
        div_den = signed'(fin_den);
      end
      OP_POW_START: begin
        div_num = DIV_W'(v_r) <<< FRAC_BITS;
        div_den = signed'(DIV_W'(h_eff));
      end
      default: div_start = 1'b0;
    endcase
  end

  lid_div u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .quo(div_q), .done(div_done)
  );

  assign stat.n_pts     = n_pts;
  assign stat.order     = ord_r;
  assign stat.in_span   = !(xp_next > XP_W'(xl_r) || xp_next < XP_W'(x0_r));
  assign stat.den_zero  = den_w == '0;
  assign stat.div_done  = div_done;
  assign stat.out_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ord_r     <= ORDER_RESET;
      step_r    <= STEP_RESET;
      pcnt_r    <= COUNT_RESET;
      load_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ORDER: ord_r  <= cfg_data[1:0];
          REG_STEP:  step_r <= cfg_data[30:0];
          REG_COUNT: pcnt_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_LOAD) load_idx <= (slot_inc >= n_pts) ? '0 : slot_inc;
      if (cmd.op == OP_OUT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_QSTART: begin
        q_r   <= query_x;
        s_r   <= '0;
        v_r   <= '0;
        oos_r <= 1'b0;
        sat_r <= 1'b0;
      end
      OP_CAP_X0: x0_r <= x_rd;
      OP_CAP_XL: xl_r <= x_rd;
      OP_EV_START: begin
        xp_r  <= xp_next;
        acc_r <= '0;
        if (!stat.in_span) oos_r <= 1'b1;
      end
      OP_K_INIT: lw_r <= 32'(ONE_FX);
      OP_K_CAP: begin
        xk_r <= x_rd;
        yk_r <= y_rd;
      end
      OP_I_MUL: begin
        if (stat.den_zero) begin
          lw_r  <= lw_special;
          sat_r <= 1'b1;
        end else begin
          prod_r <= mul_li[63:0];
          den_r  <= den_w;
        end
      end
      OP_LW_UPD: begin
        lw_r <= clamp32(div_q);
        if (ovf32(div_q)) sat_r <= 1'b1;
      end
      OP_Y_MUL: prod_r <= yk_r * lw_r;
      OP_Y_ACC: acc_r <= acc_r + ((prod_r + (prod_r[63] ? FRAC_MASK : 64'sd0)) >>> FRAC_BITS);
      OP_EV_CLAMP: begin
        p_r <= clamp32(acc_r);
        if (ovf32(acc_r)) sat_r <= 1'b1;
      end
      OP_EV_SUM: s_r <= s_r + S_W'(cp);
      OP_V_UPD: begin
        v_r <= clamp32(div_q);
        if (ovf32(div_q)) sat_r <= 1'b1;
      end
      OP_OUT: begin
        derivative  <= v_r;
        out_of_span <= oos_r;
        saturated   <= sat_r;
      end
      default: ;
    endcase
  end

endmodule

// ----- src/lid_ctrl.sv -----
// Controller: sequences evaluation points, Lagrange terms and the final divisions.
module lid_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               kind,
  output logic               in_ready,
  input  logic               out_ready,
  input  lid_pkg::lid_stat_t stat,
  output lid_pkg::lid_cmd_t  cmd
);
  import lid_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_X0    = 19'h00002,
    S_XL    = 19'h00004,
    S_EV    = 19'h00008,
    S_KRD   = 19'h00010,
    S_KCAP  = 19'h00020,
    S_IRD   = 19'h00040,
    S_IMUL  = 19'h00080,
    S_IDIV  = 19'h00100,
    S_IWAIT = 19'h00200,
    S_YMUL  = 19'h00400,
    S_YACC  = 19'h00800,
    S_EVCLP = 19'h01000,
    S_EVSUM = 19'h02000,
    S_FDIV  = 19'h04000,
    S_FWAIT = 19'h08000,
    S_PDIV  = 19'h10000,
    S_PWAIT = 19'h20000,
    S_OUT   = 19'h40000
  } state_t;

  state_t           state, state_next;
  logic [2:0]       e, e_next;
  logic [CNT_W-1:0] k, k_next, i, i_next;
  logic [CNT_W-1:0] n_m1;
  logic [1:0]       pw, pw_next;
  logic             last_ev;

  assign in_ready = state == S_IDLE;
  assign n_m1     = stat.n_pts - 1'b1;
  assign last_ev  = (e == EV_MINUS_2H && stat.order != ORD_SECOND) || e == EV_CENTER;

  always_comb begin
    state_next   = state;
    e_next       = e;
    k_next       = k;
    i_next       = i;
    pw_next      = pw;
    cmd.op       = OP_NONE;
    cmd.addr     = '0;
    cmd.eval_idx = e;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!kind) begin
            cmd.op = OP_LOAD;
          end else begin
            cmd.op     = OP_QSTART;
            e_next     = EV_PLUS_H;
            state_next = (stat.order == ORD_NONE) ? S_OUT : S_X0;
          end
        end
      end
      S_X0: begin
        cmd.op     = OP_CAP_X0;
        cmd.addr   = n_m1[IDX_W-1:0];
        state_next = S_XL;
      end
      S_XL: begin
        cmd.op     = OP_CAP_XL;
        state_next = S_EV;
      end
      S_EV: begin
        cmd.op     = OP_EV_START;
        k_next     = '0;
        state_next = stat.in_span ? S_KRD : S_EVCLP;
      end
      S_KRD: begin
        cmd.op     = OP_K_INIT;
        cmd.addr   = k[IDX_W-1:0];
        i_next     = '0;
        state_next = S_KCAP;
      end
      S_KCAP: begin
        cmd.op     = OP_K_CAP;
        state_next = S_IRD;
      end
      S_IRD: begin
        if (i == stat.n_pts) begin
          state_next = S_YMUL;
        end else if (i == k) begin
          i_next = i + 1'b1;
        end else begin
          cmd.addr   = i[IDX_W-1:0];
          state_next = S_IMUL;
        end
      end
      S_IMUL: begin
        cmd.op = OP_I_MUL;
        if (stat.den_zero) begin
          i_next     = i + 1'b1;
          state_next = S_IRD;
        end else begin
          state_next = S_IDIV;
        end
      end
      S_IDIV: begin
        cmd.op     = OP_DIV_START;
        state_next = S_IWAIT;
      end
      S_IWAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_LW_UPD;
          i_next     = i + 1'b1;
          state_next = S_IRD;
        end
      end
      S_YMUL: begin
        cmd.op     = OP_Y_MUL;
        state_next = S_YACC;
      end
      S_YACC: begin
        cmd.op     = OP_Y_ACC;
        k_next     = k + 1'b1;
        state_next = (k == n_m1) ? S_EVCLP : S_KRD;
      end
      S_EVCLP: begin
        cmd.op     = OP_EV_CLAMP;
        state_next = S_EVSUM;
      end
      S_EVSUM: begin
        cmd.op = OP_EV_SUM;
        if (last_ev) begin
          state_next = S_FDIV;
        end else begin
          e_next     = e + 1'b1;
          state_next = S_EV;
        end
      end
      S_FDIV: begin
        cmd.op     = OP_FIN_START;
        state_next = S_FWAIT;
      end
      S_FWAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_V_UPD;
          pw_next    = 2'd1;
          state_next = (stat.order == ORD_FIRST) ? S_OUT : S_PDIV;
        end
      end
      S_PDIV: begin
        cmd.op     = OP_POW_START;
        state_next = S_PWAIT;
      end
      S_PWAIT: begin
        if (stat.div_done) begin
          cmd.op     = OP_V_UPD;
          pw_next    = pw + 1'b1;
          state_next = (pw + 1'b1 == stat.order) ? S_OUT : S_PDIV;
        end
      end
      S_OUT: begin
        if (!stat.out_valid || out_ready) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      e     <= '0;
      k     <= '0;
      i     <= '0;
      pw    <= '0;
    end else begin
      state <= state_next;
      e     <= e_next;
      k     <= k_next;
      i     <= i_next;
      pw    <= pw_next;
    end
  end

endmodule

// ----- src/lid_checker.sv -----
// Port-level checker for the interpolating differentiator, bound to the top level.
module lid_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] derivative,
  input logic        out_of_span,
  input logic        saturated
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A waiting result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(derivative) &&
                                $stable(out_of_span) && $stable(saturated))
    else $error("result changed while stalled");

  // A load beat never produces a result.
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !kind |=> !$rose(out_valid))
    else $error("result appeared after a load");

  // A query keeps the input side closed while it is worked on.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind |=> !in_ready)
    else $error("input accepted during a query");

endmodule

bind lagrange_interp_derivative lid_checker u_chk (.*);

// ----- bench/tb_top.sv -----
// Self-checking testbench for the Lagrange interpolating differentiator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lid_pkg::*;

  // Random sequences keep n small most of the time, so the whole run stays
  // well under this limit.
  localparam int CYCLE_LIMIT = 6_000_000;
  // The block takes each load beat in the idle state and produces no result for it.
  // A short quiet spell is therefore enough before a register write.
  localparam int SETTLE_CYCLES = 100;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct {
    logic signed [31:0] deriv;
    logic               oos;
    logic               sat;
  } deriv_result_t;

  // The scoreboard mirrors the sample store and the registers. It turns each
  // accepted query beat into the expected derivative, out-of-span and
  // saturation flags, and checks the results in order.
  class deriv_scoreboard;
    localparam longint UNIT = longint'(1) << FRAC_BITS;
    localparam longint S32_HI = 64'sd2147483647;
    localparam longint S32_LO = -64'sd2147483648;

    longint         pt_x[MAX_POINTS];
    longint         pt_y[MAX_POINTS];
    int             load_slot;
    logic [1:0]     order;
    logic [30:0]    step;
    logic [3:0]     count;
    deriv_result_t  pending_q[$];
    int             errors;

    function new();
      foreach (pt_x[i]) begin
        pt_x[i] = 0;
        pt_y[i] = 0;
      end
      load_slot = 0;
      order = ORDER_RESET;
      step = STEP_RESET;
      count = COUNT_RESET;
      errors = 0;
    endfunction

    function int points_used();
      if (count < 2) return 2;
      if (count > MAX_POINTS) return MAX_POINTS;
      return count;
    endfunction

    // Slot that the next load beat will write.
    function int next_slot();
      return (load_slot < points_used()) ? load_slot : 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        REG_ORDER: order = data[1:0];
        REG_STEP:  step = data[30:0];
        REG_COUNT: count = data[3:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, inout bit sat);
      if (v > S32_HI) begin
        sat = 1;
        return S32_HI;
      end
      if (v < S32_LO) begin
        sat = 1;
        return S32_LO;
      end
      return v;
    endfunction

    // Value of the Lagrange polynomial through the first n points at xp.
    function longint poly_at(int n, longint xp, inout bit oos, inout bit sat);
      longint acc, lw, num, den;
      acc = 0;
      if (xp > pt_x[n-1] || xp < pt_x[0]) begin
        oos = 1;
        return 0;
      end
      for (int k = 0; k < n; k++) begin
        lw = UNIT;
        for (int i = 0; i < n; i++) begin
          if (i == k) continue;
          num = xp - pt_x[i];
          den = pt_x[k] - pt_x[i];
          if (den == 0) begin
            // Coincident abscissas: the weight jumps to the signed extreme, or to zero.
            sat = 1;
            if (num == 0 || lw == 0) lw = 0;
            else lw = ((lw < 0) != (num < 0)) ? S32_LO : S32_HI;
          end else begin
            lw = clip(lw * num / den, sat);
          end
        end
        acc += pt_y[k] * lw / UNIT;
      end
      return clip(acc, sat);
    endfunction

    function void note_item(logic kind, logic signed [31:0] sx, logic signed [31:0] sy,
                            logic signed [31:0] qx);
      int n, slot, ord;
      longint h, xp, a, b, c, d, m, s, v, den;
      bit oos, sat, moos, msat;
      deriv_result_t r;
      n = points_used();
      if (kind == 1'b0) begin
        slot = next_slot();
        pt_x[slot] = longint'(sx);
        pt_y[slot] = longint'(sy);
        load_slot = (slot + 1 >= n) ? 0 : slot + 1;
        return;
      end
      oos = 0; sat = 0; moos = 0; msat = 0;
      h = (step == 0) ? 1 : longint'({33'd0, step});
      xp = longint'(qx);
      a = poly_at(n, xp + h, oos, sat);
      b = poly_at(n, xp - h, oos, sat);
      c = poly_at(n, xp + 2 * h, oos, sat);
      d = poly_at(n, xp - 2 * h, oos, sat);
      m = poly_at(n, xp, moos, msat);
      ord = order;
      case (order)
        ORD_FIRST: begin
          s = 8 * a - 8 * b - c + d;
          den = 12;
        end
        ORD_SECOND: begin
          s = 16 * a + 16 * b - c - d - 30 * m;
          den = 12;
          oos = oos | moos;
          sat = sat | msat;
        end
        ORD_THIRD: begin
          s = -2 * a + 2 * b + c - d;
          den = 2;
        end
        default: begin
          r.deriv = '0; r.oos = 0; r.sat = 0;
          pending_q.push_back(r);
          return;
        end
      endcase
      v = clip(s * UNIT / (den * h), sat);
      for (int p = 1; p < ord; p++) v = clip(v * UNIT / h, sat);
      r.deriv = v[31:0];
      r.oos = oos;
      r.sat = sat;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] deriv, logic oos, logic sat);
      deriv_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat: derivative %0d", deriv);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (deriv !== e.deriv) begin
        $error("derivative: expected %0d, got %0d", e.deriv, deriv);
        errors++;
      end
      if (oos !== e.oos) begin
        $error("out_of_span: expected %0b, got %0b", e.oos, oos);
        errors++;
      end
      if (sat !== e.sat) begin
        $error("saturated: expected %0b, got %0b", e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               kind;
  logic signed [31:0] sample_x;
  logic signed [31:0] sample_y;
  logic signed [31:0] query_x;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] derivative;
  logic               out_of_span;
  logic               saturated;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;

  deriv_scoreboard sb;
  int unsigned cycles;
  int tx_gap_pct;
  int rx_stall_pct;
  int item_count;

  lagrange_interp_derivative DUT (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Global watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side. The beat is checked on the sampled values of this edge, and
  // out_ready gets a fresh random value for the next one.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(derivative, out_of_span, saturated);
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Drives one input beat and holds it until accepted. The valid line is lowered only for a
  // random gap before the beat, so back-to-back beats need a single assignment per edge.
  task automatic send_item(logic k, logic signed [31:0] sx, logic signed [31:0] sy,
                           logic signed [31:0] qx);
    if ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_gap_pct);
    end
    in_valid <= 1'b1;
    kind <= k;
    sample_x <= sx;
    sample_y <= sy;
    query_x <= qx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(k, sx, sy, qx);
    item_count++;
  endtask

  task automatic load_point(int x, int y);
    send_item(1'b0, x, y, $urandom);
  endtask

  task automatic query_at(int x);
    send_item(1'b1, $urandom, $urandom, x);
  endtask

  // Register writes follow one another directly; the channel is released by
  // the next idle wait.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Releases both request channels, waits for every outstanding result, then
  // lets the block settle so that a register write finds it idle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [1:0] ord, logic [30:0] h, logic [3:0] n);
    wait_idle();
    write_reg(REG_ORDER, {30'd0, ord});
    write_reg(REG_STEP, {1'b0, h});
    write_reg(REG_COUNT, {28'd0, n});
    wait_idle();
  endtask

  // One well-formed sequence: a fresh ascending point set loaded so that the
  // slots end up in order, then a few queries inside the span. Now and then
  // two abscissas are swapped or made equal to break the ordering.
  task automatic point_set_sequence();
    int n, start, gap, span;
    int xs[MAX_POINTS];
    int ys[MAX_POINTS];
    n = sb.points_used();
    start = sb.next_slot();
    xs[0] = int'($urandom_range(40 << 16)) - (20 << 16);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        gap = int'($urandom_range(4 << 16, 1 << 16));
        xs[i] = xs[i-1] + gap;
      end
      if ($urandom_range(7) == 0) ys[i] = $urandom;
      else ys[i] = int'($urandom_range(100 << 16)) - (50 << 16);
    end
    if ($urandom_range(7) == 0) begin
      if ($urandom_range(1) == 0) xs[1] = xs[0];
      else begin
        span = xs[0];
        xs[0] = xs[n-1];
        xs[n-1] = span;
      end
    end
    for (int i = 0; i < n; i++)
      load_point(xs[(start + i) % n], ys[(start + i) % n]);
    span = xs[n-1] - xs[0];
    repeat ($urandom_range(3, 1)) begin
      if (span > 0) query_at(xs[0] + int'($urandom_range(span)));
      else query_at(xs[0]);
    end
  endtask

  // Random configuration for the next sequence; n stays small most of the
  // time because query latency grows with the square of n.
  task automatic random_regs();
    logic [1:0] ord;
    logic [30:0] h;
    logic [3:0] n;
    ord = ($urandom_range(9) == 0) ? ORD_NONE : 2'($urandom_range(3, 1));
    if ($urandom_range(7) == 0) h = 31'($urandom);
    else h = 31'($urandom_range(32768, 1638));
    if ($urandom_range(39) == 0) n = 4'($urandom);
    else if ($urandom_range(5) == 0) n = 4'd4;
    else n = 4'($urandom_range(3, 2));
    set_regs(ord, h, n);
  endtask

  task automatic random_phase(int gap_pct, int stall_pct);
    int goal;
    tx_gap_pct = gap_pct;
    rx_stall_pct = stall_pct;
    goal = item_count + ITEMS_PER_PHASE;
    while (item_count < goal) begin
      random_regs();
      if ($urandom_range(4) == 0) begin
        // Noise: raw beats with arbitrary content. Every slot was written
        // during the directed part, so queries never read an empty entry.
        repeat ($urandom_range(6, 3))
          send_item(1'($urandom), $urandom, $urandom, $urandom);
      end else begin
        point_set_sequence();
      end
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    item_count = 0;
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    kind = 1'b0;
    sample_x = '0;
    sample_y = '0;
    query_x = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ORDER;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full point set at the reset settings: this writes every slot once, so
    // later queries at any point count read only written entries.
    for (int i = 0; i < MAX_POINTS; i++) load_point(i << 16, (i * i) << 16);
    query_at(32'sh0003_8000);
    // A count above the store depth behaves like a full store.
    set_regs(ORD_SECOND, 31'd19661, 4'd15);
    query_at(32'sh0003_8000);

    // Count zero acts as two points; extreme abscissas and ordinates with
    // the smallest step drive every stage into saturation.
    set_regs(ORD_THIRD, 31'd1, 4'd0);
    load_point(32'sh8000_0000, 32'sh7FFF_FFFF);
    load_point(32'sh7FFF_FFFF, 32'sh8000_0000);
    query_at(32'sh0000_0000);
    query_at(32'sh7FFF_FFFF);
    query_at(32'sh8000_0000);

    // Order zero returns a zero result with both flags clear.
    set_regs(ORD_NONE, 31'd1, 4'd2);
    query_at(32'sh0000_0000);

    // Zero step acts as the smallest step; two equal abscissas.
    set_regs(ORD_SECOND, 31'd0, 4'd2);
    load_point(32'sh0005_0000, 32'sh0001_0000);
    load_point(32'sh0005_0000, 32'sh0002_0000);
    query_at(32'sh0005_0000);

    // Points stored out of order make every stencil point fall outside.
    set_regs(ORD_FIRST, 31'h7FFF_FFFF, 4'd2);
    load_point(32'sh0004_0000, 32'sh0001_0000);
    load_point(32'sh0001_0000, 32'sh0002_0000);
    query_at(32'sh0002_0000);

    // Three points with a fourth load that wraps around to slot zero.
    set_regs(ORD_FIRST, 31'd6554, 4'd3);
    load_point(32'sh0000_0000, 32'sh0000_0000);
    load_point(32'sh0001_0000, 32'sh0001_0000);
    load_point(32'sh0002_0000, 32'sh0004_0000);
    load_point(-32'sh0001_0000, 32'sh0001_0000);
    query_at(32'sh0000_8000);

    random_phase(8, 82);
    random_phase(82, 8);
    random_phase(0, 0);

    wait_idle();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
